### rtl/core/pee_pkg.sv
// shared types and constants of the postfix expression evaluator
`default_nettype none
package pee_pkg;

  localparam int unsigned WordW = 32;

  // ascii codes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  // operations of the shared arithmetic unit
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic divz;
  } alu_rsp_t;

endpackage
`default_nettype wire

### rtl/core/pee_alu.sv
// shared arithmetic unit: add, subtract, shift-add multiply, restoring signed divide
`default_nettype none
module pee_alu
  import pee_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire alu_req_t         req,
  input  wire logic [WordW-1:0] a,
  input  wire logic [WordW-1:0] b,
  output alu_rsp_t              rsp,
  output logic [WordW-1:0]      result
);

  localparam int unsigned CntW = $clog2(WordW);

  logic            busy;
  logic            fix;
  logic [CntW-1:0] cnt;
  alu_op_t         op_q;
  logic            neg_q;
  logic [WordW-1:0] work_a;
  logic [WordW-1:0] work_b;
  logic [WordW:0]   work_acc;

  logic [WordW-1:0] a_abs;
  logic [WordW-1:0] b_abs;
  logic [WordW:0]   rem_sh;
  logic [WordW:0]   diff;

  // operand magnitudes for the divide
  assign a_abs = a[WordW-1] ? (~a + 1'b1) : a;
  assign b_abs = b[WordW-1] ? (~b + 1'b1) : b;

  // one restoring divide step
  assign rem_sh = {work_acc[WordW-1:0], work_a[WordW-1]};
  assign diff   = rem_sh - {1'b0, work_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      fix      <= 1'b0;
      rsp.done <= 1'b0;
      rsp.divz <= 1'b0;
    end else begin
      // add, subtract and divide by zero finish at once, serial ops after the pickup
      rsp.done <= (req.start && ((req.op == OP_ADD) || (req.op == OP_SUB) ||
                                 ((req.op == OP_DIV) && (b == '0)))) ||
                  (!req.start && !busy && fix);
      fix      <= !req.start && busy && (cnt == CntW'(WordW - 1));
      if (req.start) begin
        op_q     <= req.op;
        rsp.divz <= (req.op == OP_DIV) && (b == '0);
        unique case (req.op)
          OP_ADD: begin
            result <= a + b;
          end
          OP_SUB: begin
            result <= a - b;
          end
          OP_MUL: begin
            work_a   <= b;
            work_b   <= a;
            work_acc <= '0;
            cnt      <= '0;
            busy     <= 1'b1;
          end
          OP_DIV: begin
            if (b == '0) begin
              result <= '0;
            end else begin
              work_a   <= a_abs;
              work_b   <= b_abs;
              work_acc <= '0;
              neg_q    <= a[WordW-1] ^ b[WordW-1];
              cnt      <= '0;
              busy     <= 1'b1;
            end
          end
          default: ;
        endcase
      end else if (busy) begin
        // one multiply or divide step per cycle
        if (op_q == OP_MUL) begin
          if (work_a[0]) begin
            work_acc <= {1'b0, work_acc[WordW-1:0] + work_b};
          end
          work_a <= {1'b0, work_a[WordW-1:1]};
          work_b <= {work_b[WordW-2:0], 1'b0};
        end else begin
          if (!diff[WordW]) begin
            work_acc <= diff;
            work_a   <= {work_a[WordW-2:0], 1'b1};
          end else begin
            work_acc <= rem_sh;
            work_a   <= {work_a[WordW-2:0], 1'b0};
          end
        end
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(WordW - 1)) begin
          busy <= 1'b0;
        end
      end else if (fix) begin
        // final sign fix of the quotient or product pickup
        if (op_q == OP_MUL) begin
          result <= work_acc[WordW-1:0];
        end else begin
          result <= neg_q ? (~work_a + 1'b1) : work_a;
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/postfix_expression_evaluator.sv
// top level of the postfix expression evaluator
`default_nettype none
// Evaluates an ASCII postfix expression given one character per item, with
// last marking the final character; one result (value and status) follows
// each expression. A separator pushes any pending number, and * and / use
// the 32-step shared multiply/divide unit with its start and pickup. The
// final character adds the stack read and the hand-over, with its number
// pushed first when it is a digit, and waits while the output register
// still holds an unaccepted result. The stack is a memory of STACK_DEPTH
// 32-bit words with one registered read port. The input is stalled while
// an item is being worked on; a finished result sits in the output
// register while the next expression is taken in.
module postfix_expression_evaluator
  import pee_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  ch,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [31:0] value,
  output logic [1:0]       status
);

  localparam int unsigned SpW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IdxW = $clog2(STACK_DEPTH);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_FLUSH   = 8'b0000_0010,
    S_RD_R    = 8'b0000_0100,
    S_RD_L    = 8'b0000_1000,
    S_CALC    = 8'b0001_0000,
    S_WAIT    = 8'b0010_0000,
    S_FIN_RD  = 8'b0100_0000,
    S_FIN_OUT = 8'b1000_0000
  } state_t;

  state_t          state;
  logic [SpW-1:0]  sp;
  logic [WordW-1:0] acc;
  logic            pending;
  status_t         err;
  logic [7:0]      ch_q;
  logic            fin_q;
  logic [WordW-1:0] rhs;

  logic [WordW-1:0] mem [STACK_DEPTH];
  logic [WordW-1:0] rdata;
  logic [IdxW-1:0]  rd_addr;
  logic             wr_en;
  logic [IdxW-1:0]  wr_addr;
  logic [WordW-1:0] wr_data;

  logic [SpW-1:0]  sp_m1;
  logic [SpW-1:0]  sp_m2;
  logic            is_digit;
  logic            is_op;
  logic            full;
  logic            out_free;
  alu_op_t         op_code;
  alu_req_t        alu_req;
  alu_rsp_t        alu_rsp;
  logic [WordW-1:0] alu_result;

  assign sp_m1    = sp - 1'b1;
  assign sp_m2    = sp - SpW'(2);
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_op    = (ch_q == CH_PLUS) || (ch_q == CH_MINUS) ||
                    (ch_q == CH_STAR) || (ch_q == CH_SLASH);
  assign full     = (sp == SpW'(STACK_DEPTH));
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // operator decode
  always_comb begin
    unique case (ch_q)
      CH_PLUS:  op_code = OP_ADD;
      CH_MINUS: op_code = OP_SUB;
      CH_STAR:  op_code = OP_MUL;
      default:  op_code = OP_DIV;
    endcase
  end

  assign alu_req.start = (state == S_CALC);
  assign alu_req.op    = op_code;

  pee_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .a      (rdata),
    .b      (rhs),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  // stack read address and write port
  always_comb begin
    rd_addr = sp_m1[IdxW-1:0];
    if (state == S_RD_L) begin
      rd_addr = sp_m2[IdxW-1:0];
    end
    wr_en   = 1'b0;
    wr_addr = sp[IdxW-1:0];
    wr_data = acc;
    if (state == S_FLUSH) begin
      wr_en = pending && !full;
    end else if (state == S_WAIT) begin
      wr_en   = alu_rsp.done;
      wr_addr = sp_m2[IdxW-1:0];
      wr_data = alu_result;
    end
  end

  // operand stack memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      acc       <= '0;
      pending   <= 1'b0;
      err       <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      // output register: load a finished result, drop an accepted one
      if ((state == S_FIN_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            // a final digit goes through flush as a non-operator
            ch_q  <= is_digit ? CH_ZERO : ch;
            fin_q <= last;
            if (is_digit) begin
              acc     <= {acc[WordW-4:0], 3'b000} + {acc[WordW-2:0], 1'b0}
                         + WordW'(ch - CH_ZERO);
              pending <= 1'b1;
              if (last) begin
                state <= S_FLUSH;
              end
            end else begin
              state <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          // push the pending number, then dispatch
          if (pending) begin
            if (full) begin
              if (err == ST_OK) err <= ST_OVER;
            end else begin
              sp <= sp + 1'b1;
            end
          end
          acc     <= '0;
          pending <= 1'b0;
          if (is_op) begin
            if (!pending && (sp < SpW'(2))) begin
              if (err == ST_OK) err <= ST_UNDER;
              state <= fin_q ? S_FIN_RD : S_IDLE;
            end else begin
              state <= S_RD_R;
            end
          end else begin
            state <= fin_q ? S_FIN_RD : S_IDLE;
          end
        end
        S_RD_R: begin
          // a push in flush may have left a single operand
          if (sp < SpW'(2)) begin
            if (err == ST_OK) err <= ST_UNDER;
            state <= fin_q ? S_FIN_RD : S_IDLE;
          end else begin
            state <= S_RD_L;
          end
        end
        S_RD_L: begin
          rhs   <= rdata;
          state <= S_CALC;
        end
        S_CALC: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (alu_rsp.done) begin
            sp <= sp_m1;
            if (alu_rsp.divz && (err == ST_OK)) begin
              err <= ST_DIVZ;
            end
            state <= fin_q ? S_FIN_RD : S_IDLE;
          end
        end
        S_FIN_RD: begin
          state <= S_FIN_OUT;
        end
        S_FIN_OUT: begin
          // hand over the result once the output register is free
          if (out_free) begin
            if (sp != '0) begin
              value  <= rdata;
              status <= err;
            end else begin
              value  <= '0;
              status <= (err == ST_OK) ? ST_UNDER : err;
            end
            sp      <= '0;
            err     <= ST_OK;
            acc     <= '0;
            pending <= 1'b0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
